// File: rtl/sliding_window_median_assert.svh
// Assertion macros for the sliding window median block.
// Needs clk and rst in the scope where they are used.
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWM_ASSERT_IMP(lbl, ante, cons, msg)
`define SWM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/swm_pkg.sv
// Shared types and constants for the sliding window median block.
// No dependencies.
package swm_pkg;

  localparam int WS_BITS  = 7;   // window_size register width
  localparam int IN_BITS  = 32;  // sample port width
  localparam int OUT_BITS = 33;  // median_twice port width

  localparam logic [WS_BITS-1:0] WS_RESET = 7'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_TAP,
    ST_EMIT
  } swm_state_t;

  // flags one cell hands to its neighbors
  typedef struct packed {
    logic ge_old;  // cell sits at or after the leaving sample
    logic le_s;    // cell value <= new sample
    logic below;   // after removal, this slot stays ahead of the new sample
  } swm_flags_t;

endpackage

// File: rtl/swm_cell.sv
// One slot of the sorted row: holds a value and rebuilds it from neighbors.
// Depends on swm_pkg.
module swm_cell #(
  parameter int INDEX = 0,
  parameter int KW    = 7,
  parameter int SB    = 32
) (
  input  logic                  clk,
  input  logic                  upd,
  input  logic signed [SB-1:0]  s,
  input  logic signed [SB-1:0]  old,
  input  logic                  full,
  input  logic [KW-1:0]         limit,
  input  logic [KW-1:0]         lo_idx,
  input  logic [KW-1:0]         hi_idx,
  input  logic signed [SB-1:0]  prev_val,
  input  swm_pkg::swm_flags_t   prev_flags,
  input  logic signed [SB-1:0]  next_val,
  input  swm_pkg::swm_flags_t   next_flags,
  output logic signed [SB-1:0]  val,
  output swm_pkg::swm_flags_t   flags,
  output logic [SB-1:0]         lo_term,
  output logic [SB-1:0]         hi_term
);
  import swm_pkg::*;

  logic                 ge_old;
  logic                 le_s;
  logic                 below;
  logic signed [SB-1:0] b_here;
  logic signed [SB-1:0] b_prev;
  logic signed [SB-1:0] val_next;

  always_comb begin
    ge_old = full && (val >= old);
    le_s   = (val <= s);
    below  = (KW'(INDEX) < limit) && (ge_old ? next_flags.le_s : le_s);
    // row after removal of the leaving sample, seen at this slot and the one before
    b_here = ge_old ? next_val : val;
    b_prev = prev_flags.ge_old ? val : prev_val;
    if (below) begin
      val_next = b_here;
    end else if (prev_flags.below) begin
      val_next = s;
    end else begin
      val_next = b_prev;
    end
  end

  assign flags   = '{ge_old: ge_old, le_s: le_s, below: below};
  assign lo_term = (KW'(INDEX) == lo_idx) ? val : '0;
  assign hi_term = (KW'(INDEX) == hi_idx) ? val : '0;

  always_ff @(posedge clk) begin
    if (upd) begin
      val <= val_next;
    end
  end

endmodule

// File: rtl/swm_tap_tree.sv
// Registered OR tree that pulls the two middle cells out of the sorted row.
// Depends on swm_pkg.
module swm_tap_tree #(
  parameter int N  = 64,
  parameter int SB = 32
) (
  input  logic                  clk,
  input  logic [N-1:0][SB-1:0]  lo_terms,
  input  logic [N-1:0][SB-1:0]  hi_terms,
  output logic [SB-1:0]         lo_val,
  output logic [SB-1:0]         hi_val
);
  import swm_pkg::*;

  localparam int GROUP = 8;
  localparam int NG    = (N + GROUP - 1) / GROUP;

  logic [NG*GROUP-1:0][SB-1:0] lo_pad;
  logic [NG*GROUP-1:0][SB-1:0] hi_pad;
  logic [NG-1:0][SB-1:0]       lo_grp;
  logic [NG-1:0][SB-1:0]       hi_grp;

  always_comb begin
    lo_pad = '0;
    hi_pad = '0;
    lo_pad[N-1:0] = lo_terms;
    hi_pad[N-1:0] = hi_terms;
  end

  for (genvar g = 0; g < NG; g++) begin : g_grp
    logic [SB-1:0] lo_or;
    logic [SB-1:0] hi_or;
    always_comb begin
      lo_or = '0;
      hi_or = '0;
      for (int i = 0; i < GROUP; i++) begin
        lo_or = lo_or | lo_pad[g*GROUP+i];
        hi_or = hi_or | hi_pad[g*GROUP+i];
      end
    end
    always_ff @(posedge clk) begin
      lo_grp[g] <= lo_or;
      hi_grp[g] <= hi_or;
    end
  end

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int g = 0; g < NG; g++) begin
      lo_val = lo_val | lo_grp[g];
      hi_val = hi_val | hi_grp[g];
    end
  end

endmodule

// File: rtl/sliding_window_median.sv
// Top level of the sliding window median filter.
// Depends on swm_pkg, swm_cell, swm_tap_tree and sliding_window_median_assert.svh.

// Streaming median over the last k samples, k set by window_size (0 acts as 1, values
// above WINDOW_MAX act as WINDOW_MAX). Each sample goes through accept (the
// arrival buffer is written and the leaving sample read), sort (every cell of the
// sorted row drops the leaving value and makes room for the new one in a single
// step, each cell looking only at its two neighbors), tap (first level of the OR
// tree that picks the middle cells) and emit (sum of the two middle cells into the
// output register). The output register lets a new request in while a result still
// waits; an unread result stalls the emit step. median_twice is twice the median:
// twice the middle cell for odd k, the sum of both middle cells for even k. No result
// comes until k samples are held. start_of_sequence empties the window before its
// sample is taken, and a write of window_size empties it too. No clearing pass
// after reset.
module sliding_window_median #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [swm_pkg::IN_BITS-1:0] sample,
  input  logic                              start_of_sequence,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [swm_pkg::OUT_BITS-1:0] median_twice,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swm_pkg::WS_BITS-1:0]       window_size
);
  import swm_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int KW = $clog2(WINDOW_MAX + 1);              // holds 0..WINDOW_MAX
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int PW = AW + 1;
  localparam int CW = (KW > WS_BITS) ? KW : WS_BITS;

  swm_state_t state, state_next;

  logic [WS_BITS-1:0]   win_size;
  logic [KW-1:0]        fill;
  logic [KW-1:0]        fill_next;
  logic [KW-1:0]        eff_fill;
  logic [AW-1:0]        wptr;
  logic [AW-1:0]        wptr_next;
  logic [AW-1:0]        rd_addr;
  logic                 emit;

  logic signed [SB-1:0] sample_reg;
  logic signed [SB-1:0] old_val;
  logic signed [SB-1:0] arrival_mem [WINDOW_MAX];

  logic [CW-1:0]        ws_ext;
  logic [CW-1:0]        k_wide;
  logic [KW-1:0]        k_eff;
  logic [KW-1:0]        lo_idx;
  logic [KW-1:0]        hi_idx;
  logic                 full;
  logic [KW-1:0]        limit;

  logic [PW-1:0]        wptr_ext;
  logic [PW-1:0]        k_ext;

  logic                 accept;
  logic                 cfg_write;
  logic                 load_out;
  logic [SB:0]          twice;

  logic signed [SB-1:0]         cell_val   [WINDOW_MAX];
  swm_flags_t                   cell_flags [WINDOW_MAX];
  logic [WINDOW_MAX-1:0][SB-1:0] lo_terms;
  logic [WINDOW_MAX-1:0][SB-1:0] hi_terms;
  logic [SB-1:0]                lo_val;
  logic [SB-1:0]                hi_val;

  // effective window length
  always_comb begin
    ws_ext = CW'(win_size);
    if (ws_ext == '0) begin
      k_wide = CW'(1);
    end else if (ws_ext > CW'(WINDOW_MAX)) begin
      k_wide = CW'(WINDOW_MAX);
    end else begin
      k_wide = ws_ext;
    end
    k_eff  = KW'(k_wide);
    lo_idx = (k_eff - KW'(1)) >> 1;
    hi_idx = k_eff >> 1;
  end

  assign accept    = in_valid && in_ready;
  assign cfg_write = cfg_valid && cfg_ready;

  // the leaving sample arrived k requests ago
  always_comb begin
    wptr_ext = PW'(wptr);
    k_ext    = PW'(k_eff);
    if (wptr_ext >= k_ext) begin
      rd_addr = AW'(wptr_ext - k_ext);
    end else begin
      rd_addr = AW'(wptr_ext + PW'(WINDOW_MAX) - k_ext);
    end
    wptr_next = (wptr == AW'(WINDOW_MAX - 1)) ? '0 : wptr + AW'(1);
    eff_fill  = (start_of_sequence || (fill > k_eff)) ? '0 : fill;
  end

  // sort step bookkeeping
  always_comb begin
    full      = (fill == k_eff);
    limit     = full ? (k_eff - KW'(1)) : fill;
    fill_next = full ? fill : (fill + KW'(1));
  end

  // arrival buffer, read before write
  always_ff @(posedge clk) begin
    if (accept) begin
      arrival_mem[wptr] <= sample[SB-1:0];
      old_val           <= arrival_mem[rd_addr];
      sample_reg        <= sample[SB-1:0];
    end
  end

  // sorted row
  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    logic signed [SB-1:0] prev_val;
    swm_flags_t           prev_flags;
    logic signed [SB-1:0] next_val;
    swm_flags_t           next_flags;

    if (j == 0) begin : g_first
      assign prev_val   = '0;
      assign prev_flags = '{ge_old: 1'b0, le_s: 1'b0, below: 1'b1};
    end else begin : g_mid
      assign prev_val   = cell_val[j-1];
      assign prev_flags = cell_flags[j-1];
    end

    if (j == WINDOW_MAX - 1) begin : g_last
      assign next_val   = '0;
      assign next_flags = '0;
    end else begin : g_inner
      assign next_val   = cell_val[j+1];
      assign next_flags = cell_flags[j+1];
    end

    swm_cell #(
      .INDEX (j),
      .KW    (KW),
      .SB    (SB)
    ) u_cell (
      .clk        (clk),
      .upd        (state == ST_SORT),
      .s          (sample_reg),
      .old        (old_val),
      .full       (full),
      .limit      (limit),
      .lo_idx     (lo_idx),
      .hi_idx     (hi_idx),
      .prev_val   (prev_val),
      .prev_flags (prev_flags),
      .next_val   (next_val),
      .next_flags (next_flags),
      .val        (cell_val[j]),
      .flags      (cell_flags[j]),
      .lo_term    (lo_terms[j]),
      .hi_term    (hi_terms[j])
    );
  end

  swm_tap_tree #(
    .N  (WINDOW_MAX),
    .SB (SB)
  ) u_tap (
    .clk      (clk),
    .lo_terms (lo_terms),
    .hi_terms (hi_terms),
    .lo_val   (lo_val),
    .hi_val   (hi_val)
  );

  assign twice = {lo_val[SB-1], lo_val} + {hi_val[SB-1], hi_val};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SORT;
        end
      end
      ST_SORT: state_next = ST_TAP;
      ST_TAP:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (!emit || !out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE: begin
        // a pending register write goes ahead of the next sample
        in_ready  = !cfg_valid;
        cfg_ready = 1'b1;
      end
      ST_EMIT: load_out = emit && (!out_valid || out_ready);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      win_size  <= WS_RESET;
      fill      <= '0;
      wptr      <= '0;
      emit      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        win_size <= window_size;
        fill     <= '0;
      end else if (accept) begin
        fill <= eff_fill;
        wptr <= wptr_next;
      end else if (state == ST_SORT) begin
        fill <= fill_next;
        emit <= (fill_next == k_eff);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      median_twice <= OUT_BITS'(twice);
    end
  end

`include "sliding_window_median_assert.svh"

  `SWM_ASSERT_NXT(a_accept_sorts, accept, state == ST_SORT, "request not sorted next cycle")
  `SWM_ASSERT_IMP(a_fill_bound, state == ST_TAP, fill <= k_eff, "fill count above window")
  `SWM_ASSERT_NXT(a_out_from_emit, (state != ST_EMIT) && !out_valid, !out_valid, "result outside emit")
  `SWM_ASSERT_NXT(a_cfg_clears, cfg_write, fill == '0, "window not emptied by config write")

endmodule

// File: tb/tb_sliding_window_median.sv
`timescale 1ns / 100ps
// Self-checking testbench for sliding_window_median: streams samples, predicts each
// window median (doubled) in-bench and compares every result. Depends on swm_pkg.
module tb_sliding_window_median;
  import swm_pkg::*;

  localparam int WINDOW_MAX    = 64;
  localparam int SETTLE_CYCLES = 12;    // pipeline is accept, sort and tap, then emit into the output register
  localparam int TAIL_CYCLES   = 20;
  localparam int STALL_CYCLES  = 300;   // long receiver hold-off
  localparam int IDLE_LIMIT    = 5000;  // cycles without any handshake before giving up
  localparam int MAX_REPORTS   = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       in_valid          = 1'b0;
  logic                       in_ready;
  logic signed [IN_BITS-1:0]  sample            = '0;
  logic                       start_of_sequence = 1'b0;
  logic                       out_valid;
  logic                       out_ready         = 1'b0;
  logic signed [OUT_BITS-1:0] median_twice;
  logic                       cfg_valid         = 1'b0;
  logic                       cfg_ready;
  logic [WS_BITS-1:0]         window_size       = '0;

  sliding_window_median #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(IN_BITS)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .sample           (sample),
    .start_of_sequence(start_of_sequence),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .median_twice     (median_twice),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .window_size      (window_size)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Window predictor: samples newest first, plus the same samples kept ascending.
  // ---------------------------------------------------------------------------
  longint             held_order  [WINDOW_MAX];
  longint             held_sorted [WINDOW_MAX];
  int unsigned        held_count  = 0;
  logic [WS_BITS-1:0] ws_setting  = WS_RESET;

  logic signed [OUT_BITS-1:0] medians_due[$];   // doubled medians still to arrive
  int                         mismatches = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // receiver hold-off request, picked up by the receiver process
  bit stall_armed = 1'b0;
  int stall_left  = 0;

  initial begin
    foreach (held_order[i]) held_order[i] = 0;
  end

  // zero acts as 1, anything past the array depth saturates
  function automatic int unsigned active_window();
    int unsigned k = ws_setting;
    if (k == 0) k = 1;
    if (k > WINDOW_MAX) k = WINDOW_MAX;
    return k;
  endfunction

  // Advance the window by one sample; returns 1 when the window is full.
  function automatic bit predict_median(input logic signed [IN_BITS-1:0] s,
                                        input logic sos,
                                        output logic signed [OUT_BITS-1:0] twice);
    int unsigned k;
    int unsigned n;
    int unsigned pos;
    longint      v;
    longint      total;
    k     = active_window();
    v     = s;
    twice = '0;
    if (sos) held_count = 0;
    if (held_count > k) held_count = 0;
    n = held_count;
    if (held_count == k) begin
      // full window: one copy of the leaving sample goes, even among equals
      pos = 0;
      while (pos < k && held_sorted[pos] != held_order[k-1]) pos++;
      if (pos < k) begin
        for (int j = pos; j + 1 < k; j++) held_sorted[j] = held_sorted[j+1];
      end
      n = k - 1;
    end else begin
      held_count++;
    end
    pos = n;
    while (pos > 0 && held_sorted[pos-1] > v) begin
      held_sorted[pos] = held_sorted[pos-1];
      pos--;
    end
    held_sorted[pos] = v;
    for (int j = WINDOW_MAX - 1; j > 0; j--) held_order[j] = held_order[j-1];
    held_order[0] = v;
    if (held_count < k) return 1'b0;
    if (k % 2) total = 2 * held_sorted[(k-1)/2];
    else       total = held_sorted[k/2-1] + held_sorted[k/2];
    twice = total[OUT_BITS-1:0];
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Inputs move on the falling edge, handshakes are seen on
  // the rising edge.
  // ---------------------------------------------------------------------------
  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // One sample request. Valid is left high on return so back-to-back requests
  // never toggle it; whoever pauses the stream lowers it.
  task automatic send_sample(input logic signed [IN_BITS-1:0] s, input logic sos = 1'b0);
    logic signed [OUT_BITS-1:0] twice;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    sample            <= s;
    start_of_sequence <= sos;
    do @(posedge clk); while (!in_ready);
    if (predict_median(s, sos, twice)) medians_due = {medians_due, twice};
    @(negedge clk);
  endtask

  // Register writes only on an idle block: drain results, then let any sample
  // that yields no result clear the pipeline.
  task automatic write_window_size(input logic [WS_BITS-1:0] value);
    in_valid <= 1'b0;
    while (medians_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid   <= 1'b1;
    window_size <= value;
    do @(posedge clk); while (!cfg_ready);
    ws_setting = value;
    held_count = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mix of full range, small values (lots of ties) and the two extremes
  function automatic logic signed [IN_BITS-1:0] pick_sample();
    case ($urandom_range(0, 5))
      2:       return $signed($urandom_range(0, 16)) - 8;
      3:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly small windows, now and then a large or out-of-range one
  function automatic logic [WS_BITS-1:0] pick_window();
    case ($urandom_range(0, 9))
      0:       return WS_BITS'($urandom_range(9, WINDOW_MAX));
      1:       return $urandom_range(0, 1) ? '0
                                            : WS_BITS'($urandom_range(WINDOW_MAX + 1, 127));
      default: return WS_BITS'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic send_random(input int count, input int sos_pct);
    repeat (count) send_sample(pick_sample(), $urandom_range(0, 99) < sos_pct);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset window of 3: extremes, fill-up with no result, restart, equal samples.
  task automatic test_default_window();
    send_sample(32'sd0);
    send_sample(32'sh7fff_ffff);          // still filling
    send_sample(32'sh8000_0000);          // {min,0,max} -> 0
    send_sample(-32'sd1);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh7fff_ffff);          // two max held
    send_sample(32'sh8000_0000, 1'b1);    // restart mid-stream
    send_sample(32'sh8000_0000);
    send_sample(32'sh8000_0000);          // twice min, most negative result
    send_sample(32'sd5);
    send_sample(32'sd5);
    send_sample(32'sd5);                  // ties leave one at a time
  endtask

  // Even windows: sum of the two middle cells; a write in mid-fill empties the window.
  task automatic test_even_window();
    write_window_size(7'd2);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh7fff_ffff);          // largest result
    send_sample(32'sh8000_0000);          // max + min = -1
    send_sample(32'sh8000_0000);
    send_sample(32'sd7, 1'b1);
    send_sample(32'sd7);
    write_window_size(7'd3);
    send_sample(32'sd9);
    send_sample(-32'sd9);                 // window never fills
    write_window_size(7'd4);
    send_sample(32'sd3);
    send_sample(32'sd1);
    send_sample(32'sd3);
    send_sample(32'sd2);
    send_sample(-32'sd3);
  endtask

  // Size zero acts as 1; full depth; all-ones and just-past-depth saturate.
  task automatic test_size_limits();
    write_window_size('0);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh8000_0000);
    send_sample(32'sd0);
    send_sample(-32'sd1);
    write_window_size('1);
    send_random(WINDOW_MAX + 16, 0);
    write_window_size(7'(WINDOW_MAX));
    send_random(WINDOW_MAX + 6, 0);
    write_window_size(7'(WINDOW_MAX + 1));
    send_random(WINDOW_MAX + 2, 0);
  endtask

  // Random windows and streams under each idling mix in turn.
  task automatic test_random_windows();
    int sent;
    int k;
    int n;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       set_idling(28, 84);
        1:       set_idling(84, 28);
        default: set_idling(0, 0);
      endcase
      sent = 0;
      while (sent < 260) begin
        write_window_size(pick_window());
        k = active_window();
        // enough samples to see results even for the deep windows
        n = k + int'($urandom_range(20, 50));
        send_random(n, 5);
        sent += n;
      end
    end
  endtask

  // Receiver stops reading for a long stretch while samples keep coming, so the
  // block backs up and drops in_ready.
  task automatic test_output_stall();
    set_idling(0, 0);
    write_window_size(7'd5);
    stall_armed = 1'b1;
    send_random(60, 3);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, or held low through a requested stall.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_armed) begin
      stall_left  = STALL_CYCLES;
      stall_armed = 1'b0;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic note_mismatch(input string what, input logic signed [OUT_BITS-1:0] want,
                               input logic signed [OUT_BITS-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: median_twice expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // each result against the oldest outstanding median
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (medians_due.size() == 0) note_mismatch("result with none due", 'x, median_twice);
      else if (median_twice !== medians_due[0])
        note_mismatch("wrong median", medians_due[0], median_twice);
      if (medians_due.size() != 0) void'(medians_due.pop_front());
    end
  end

  // watchdog: any handshake on any channel counts as progress
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[sliding_window_median] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_idling(28, 84);
    test_default_window();
    test_even_window();
    test_size_limits();
    test_random_windows();
    test_output_stall();
    in_valid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && medians_due.size() == 0) begin
      $display("[sliding_window_median] OK");
    end else begin
      $display("[sliding_window_median] ERROR");
    end
    $finish;
  end

endmodule
